// File: hw/rtl/ccz_pkg.sv
// Shared types and constants for the clock calendar with zone shift.
package ccz_pkg;

  // Item kinds carried on the input tuser bit
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  // Calendar limits
  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [3:0]  MONTH_JAN     = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;
  localparam logic [2:0]  WEEKDAY_MON   = 3'd1;
  localparam logic [2:0]  WEEKDAY_SUN   = 3'd7;
  localparam logic [4:0]  LAST_HOUR     = 5'd23;
  localparam logic [5:0]  LAST_MIN_SEC  = 6'd59;

  // Zone offsets after reset, 5-bit two's complement hours
  localparam logic [4:0] OFFSET_FIRST_RST  = 5'd2;
  localparam logic [4:0] OFFSET_SECOND_RST = 5'b11100;

  // Hour and date fields that a zone shift moves
  typedef struct packed {
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
  } cal_t;

  // One input item
  typedef struct packed {
    logic        mode;
    logic        button_pressed;
    logic [4:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [5:0]  set_seconds;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [13:0] set_year;
    logic [2:0]  set_weekday;
    logic [4:0]  set_reference_zone;
  } item_t;

  // One result item
  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        zone_is_second;
    logic        led_on;
    logic        second_event;
  } result_t;

endpackage

// File: hw/rtl/ccz_zone_shift.sv
// Zone shift: moves the hours by an offset difference and carries up to two days.
module ccz_zone_shift (
  input  ccz_pkg::cal_t base,
  input  logic [5:0]    diff,    // two's complement, -31 to +31 hours
  output ccz_pkg::cal_t shifted
);

  // Leap year test; the hundreds quotient comes from a reciprocal multiply
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [13:0] rem;
    logic        div100;
    prod   = 27'(y) * 27'd5243;
    q      = prod[26:19];
    rem    = y - 14'(q) * 14'd100;
    div100 = (rem == 14'd0);
    return ((y[1:0] == 2'b00) && !div100) || (div100 && (q[1:0] == 2'b00));
  endfunction

  // Length of a month; anything outside January to December counts 31 days
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
    logic [4:0] d;
    unique case (m)
      ccz_pkg::MONTH_FEB:            d = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:       d = 5'd30;
      default:                       d = 5'd31;
    endcase
    return d;
  endfunction

  // Step one day back, borrowing from month and year
  function automatic ccz_pkg::cal_t day_back(input ccz_pkg::cal_t c, input logic lp);
    ccz_pkg::cal_t r;
    r = c;
    if (c.day <= 5'd1) begin
      if (c.month <= ccz_pkg::MONTH_JAN) begin
        r.month = ccz_pkg::MONTH_DEC;
        r.year  = (c.year == 14'd0) ? ccz_pkg::YEAR_MAX : c.year - 14'd1;
      end else begin
        r.month = c.month - 4'd1;
      end
      r.day = month_days(r.month, lp);
    end else begin
      r.day = c.day - 5'd1;
    end
    r.weekday = (c.weekday <= ccz_pkg::WEEKDAY_MON) ? ccz_pkg::WEEKDAY_SUN
                                                    : c.weekday - 3'd1;
    return r;
  endfunction

  // Step one day forward, carrying into month and year
  function automatic ccz_pkg::cal_t day_fwd(input ccz_pkg::cal_t c, input logic lp);
    ccz_pkg::cal_t r;
    logic [5:0]    dn;
    r  = c;
    dn = {1'b0, c.day} + 6'd1;
    if (dn > {1'b0, month_days(c.month, lp)}) begin
      r.day = 5'd1;
      if (c.month >= ccz_pkg::MONTH_DEC) begin
        r.month = ccz_pkg::MONTH_JAN;
        r.year  = (c.year >= ccz_pkg::YEAR_MAX) ? 14'd0 : c.year + 14'd1;
      end else begin
        r.month = c.month + 4'd1;
      end
    end else begin
      r.day = dn[4:0];
    end
    r.weekday = ((c.weekday == 3'd0) || (c.weekday >= ccz_pkg::WEEKDAY_SUN))
                ? ccz_pkg::WEEKDAY_MON : c.weekday + 3'd1;
    return r;
  endfunction

  logic signed [6:0] h_raw;
  logic signed [6:0] h_adj;
  logic              leap_base;
  ccz_pkg::cal_t     back1, back2, fwd1, fwd2;

  // Raw shifted hour, -31 to 62
  assign h_raw = $signed({2'b00, base.hour}) + $signed({diff[5], diff});

  // A year change in the first step leaves the second step in December or
  // January, so only the leap flag of the starting year is ever needed
  assign leap_base = is_leap(base.year);
  assign back1     = day_back(base, leap_base);
  assign back2     = day_back(back1, leap_base);
  assign fwd1      = day_fwd(base, leap_base);
  assign fwd2      = day_fwd(fwd1, leap_base);

  // Pick the number of days carried from the raw hour
  always_comb begin
    shifted = base;
    h_adj   = h_raw;
    priority if (h_raw < -7'sd24) begin
      shifted = back2;
      h_adj   = h_raw + 7'sd48;
    end else if (h_raw < 7'sd0) begin
      shifted = back1;
      h_adj   = h_raw + 7'sd24;
    end else if (h_raw >= 7'sd48) begin
      shifted = fwd2;
      h_adj   = h_raw - 7'sd48;
    end else if (h_raw >= 7'sd24) begin
      shifted = fwd1;
      h_adj   = h_raw - 7'sd24;
    end else begin
      shifted = base;
      h_adj   = h_raw;
    end
    shifted.hour = h_adj[4:0];
  end

endmodule

// File: hw/rtl/ccz_core.sv
// Timekeeping state and the single-pass update for one tick or set item.
module ccz_core #(
  parameter int TICKS_PER_SECOND = 100,
  parameter int LED_ON_TICKS     = 20,
  parameter int POLL_INTERVAL    = 50
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ccz_pkg::item_t   item,
  output ccz_pkg::result_t res
);

  localparam int TICK_SPAN = (TICKS_PER_SECOND > LED_ON_TICKS) ? TICKS_PER_SECOND
                                                                : LED_ON_TICKS;
  localparam int TW = $clog2(TICK_SPAN + 1);
  localparam int PW = (POLL_INTERVAL > 1) ? $clog2(POLL_INTERVAL + 1) : 1;

  logic [TW-1:0] tick_r, tick_nxt, tick_inc;
  logic [PW-1:0] poll_r, poll_nxt;
  logic          led_r, led_nxt;
  logic [5:0]    sec_r, sec_nxt;
  logic [5:0]    min_r, min_nxt;
  ccz_pkg::cal_t cal_r, cal_nxt;
  logic          zone_r, zone_nxt;
  logic [4:0]    cur_r, cur_nxt;
  logic [4:0]    first_r, first_nxt;
  logic [4:0]    second_r, second_nxt;
  logic [4:0]    last_r, last_nxt;

  logic          toggle;
  logic          sec_evt;
  logic [4:0]    tick_target;
  logic [4:0]    ref_delta;
  logic [4:0]    set_target;
  ccz_pkg::cal_t set_cal;
  ccz_pkg::cal_t sh_base, sh_out;
  logic [5:0]    sh_diff;
  ccz_pkg::cal_t cal_mid;

  assign tick_inc = tick_r + TW'(1);

  // Button poll, zone targets and the shared shift operands
  always_comb begin
    toggle      = 1'b0;
    poll_nxt    = poll_r;
    if (poll_r != '0) begin
      poll_nxt = poll_r - PW'(1);
    end else begin
      poll_nxt = PW'(POLL_INTERVAL);
      toggle   = item.button_pressed;
    end
    zone_nxt    = zone_r ^ toggle;
    tick_target = zone_nxt ? second_r : first_r;

    // Reference zone change moves every offset by the same amount
    ref_delta   = item.set_reference_zone - last_r;
    set_target  = cur_r + ref_delta;

    set_cal.hour    = item.set_hours;
    set_cal.day     = item.set_day;
    set_cal.month   = item.set_month;
    set_cal.year    = item.set_year;
    set_cal.weekday = item.set_weekday;

    unique case (item.mode)
      ccz_pkg::MODE_SET: begin
        sh_base = set_cal;
        sh_diff = {set_target[4], set_target}
                - {item.set_reference_zone[4], item.set_reference_zone};
      end
      default: begin
        sh_base = cal_r;
        sh_diff = {tick_target[4], tick_target} - {cur_r[4], cur_r};
      end
    endcase
  end

  ccz_zone_shift u_shift (
    .base    (sh_base),
    .diff    (sh_diff),
    .shifted (sh_out)
  );

  // Next state for the item
  always_comb begin
    tick_nxt   = tick_r;
    led_nxt    = led_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    cal_nxt    = cal_r;
    cur_nxt    = cur_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    last_nxt   = last_r;
    sec_evt    = 1'b0;
    cal_mid    = cal_r;

    unique case (item.mode)
      ccz_pkg::MODE_SET: begin
        // Load, then show in the selected zone
        tick_nxt   = '0;
        sec_nxt    = item.set_seconds;
        min_nxt    = item.set_minutes;
        cal_nxt    = sh_out;
        first_nxt  = first_r + ref_delta;
        second_nxt = second_r + ref_delta;
        last_nxt   = item.set_reference_zone;
        cur_nxt    = set_target;
      end
      default: begin
        // Sub-second count and LED
        if (tick_inc >= TW'(TICKS_PER_SECOND)) begin
          tick_nxt = '0;
          sec_evt  = 1'b1;
          led_nxt  = 1'b1;
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc == TW'(LED_ON_TICKS)) begin
            led_nxt = 1'b0;
          end
        end

        // Zone toggle from the button poll
        if (toggle) begin
          cal_mid = sh_out;
          cur_nxt = tick_target;
        end
        cal_nxt = cal_mid;

        // Advance the time of day; hours wrap without a date change
        if (sec_evt) begin
          if (sec_r >= ccz_pkg::LAST_MIN_SEC) begin
            sec_nxt = 6'd0;
            if (min_r >= ccz_pkg::LAST_MIN_SEC) begin
              min_nxt      = 6'd0;
              cal_nxt.hour = (cal_mid.hour >= ccz_pkg::LAST_HOUR) ? 5'd0
                                                                 : cal_mid.hour + 5'd1;
            end else begin
              min_nxt = min_r + 6'd1;
            end
          end else begin
            sec_nxt = sec_r + 6'd1;
          end
        end
      end
    endcase
  end

  // Result for the item, taken from the updated state
  always_comb begin
    res.hours          = cal_nxt.hour;
    res.minutes        = min_nxt;
    res.seconds        = sec_nxt;
    res.day            = cal_nxt.day;
    res.month          = cal_nxt.month;
    res.year           = cal_nxt.year;
    res.weekday        = cal_nxt.weekday;
    res.zone_is_second = (item.mode == ccz_pkg::MODE_SET) ? zone_r : zone_nxt;
    res.led_on         = led_nxt;
    res.second_event   = sec_evt;
  end

  // State registers, updated once per item; poll, LED and zone on tick items only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      poll_r   <= PW'(POLL_INTERVAL);
      led_r    <= 1'b0;
      sec_r    <= '0;
      min_r    <= '0;
      cal_r    <= '0;
      zone_r   <= 1'b0;
      cur_r    <= ccz_pkg::OFFSET_FIRST_RST;
      first_r  <= ccz_pkg::OFFSET_FIRST_RST;
      second_r <= ccz_pkg::OFFSET_SECOND_RST;
      last_r   <= ccz_pkg::OFFSET_FIRST_RST;
    end else if (fire) begin
      tick_r   <= tick_nxt;
      sec_r    <= sec_nxt;
      min_r    <= min_nxt;
      cal_r    <= cal_nxt;
      cur_r    <= cur_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      last_r   <= last_nxt;
      if (item.mode == ccz_pkg::MODE_TICK) begin
        poll_r <= poll_nxt;
        led_r  <= led_nxt;
        zone_r <= zone_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/clock_calendar_with_zone_shift_unit.sv
// Top level: stream ports, input and result registers around the clock core.
//
//   channel  | direction | transfer
//   ---------+-----------+-------------------------------------------
//   in_*     | slave     | one tick (tuser 0) or one set item (tuser 1)
//   out_*    | master    | one result per input item
//
// An item is registered on arrival, processed when the result register is free
// or draining, and its result registered; one item per cycle while not stalled.
// The throughput is set by the single combinational pass through the core,
// whose longest path is the zone shift with its two chained day steps.
// Reset clears the clock to zero, the zone to the first one and the handshake.
// A stalled result holds the core; the input register still takes one item.
module clock_calendar_with_zone_shift_unit #(
  parameter int TICKS_PER_SECOND = 100,
  parameter int LED_ON_TICKS     = 20,
  parameter int POLL_INTERVAL    = 50
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // button_pressed[0], set_hours[5:1], set_minutes[11:6], set_seconds[17:12],
  // set_day[22:18], set_month[26:23], set_year[40:27], set_weekday[43:41],
  // set_reference_zone[48:44], zero[55:49]
  input  logic [55:0] in_tdata,
  // mode[0]
  input  logic        in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // hours[4:0], minutes[10:5], seconds[16:11], day[21:17], month[25:22],
  // year[39:26], weekday[42:40], zone_is_second[43], led_on[44],
  // second_event[45], zero[47:46]
  output logic [47:0] out_tdata
);

  logic             in_v_r;
  ccz_pkg::item_t   item_r;
  logic             out_v_r;
  ccz_pkg::result_t res_r;
  ccz_pkg::result_t res_nxt;
  logic             fire;
  logic             in_xfer;

  // Process when an item waits and the result register is free or draining
  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;
  assign in_xfer   = in_tvalid && in_tready;

  // Input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_xfer) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.mode               <= in_tuser;
      item_r.button_pressed     <= in_tdata[0];
      item_r.set_hours          <= in_tdata[5:1];
      item_r.set_minutes        <= in_tdata[11:6];
      item_r.set_seconds        <= in_tdata[17:12];
      item_r.set_day            <= in_tdata[22:18];
      item_r.set_month          <= in_tdata[26:23];
      item_r.set_year           <= in_tdata[40:27];
      item_r.set_weekday        <= in_tdata[43:41];
      item_r.set_reference_zone <= in_tdata[48:44];
    end
  end

  ccz_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .LED_ON_TICKS     (LED_ON_TICKS),
    .POLL_INTERVAL    (POLL_INTERVAL)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res   (res_nxt)
  );

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00,
                       res_r.second_event,
                       res_r.led_on,
                       res_r.zone_is_second,
                       res_r.weekday,
                       res_r.year,
                       res_r.month,
                       res_r.day,
                       res_r.seconds,
                       res_r.minutes,
                       res_r.hours};

endmodule

// File: tb/clock_calendar_with_zone_shift_unit_tb.sv
// Testbench for the clock calendar with zone shift: stream stimulus and a calendar scoreboard.
module clock_calendar_with_zone_shift_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICKS_PER_SECOND = 100;
  localparam int LED_ON_TICKS     = 20;
  localparam int POLL_INTERVAL    = 50;
  localparam int HOLD_OFF_CYCLES  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  // Scoreboard: tracks the clock and calendar and holds the readings still to come
  class calendar_tracker;
    int               ticks, polls, led;
    int               sec, mins, hr, dy, mon, yr, wd;
    bit               zone;
    int               cur_off, first_off, second_off, ref_off;
    int               month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    ccz_pkg::result_t expected_readings[$];
    int unsigned      errors, checked;
    int unsigned      n_ticks, n_sets, n_seconds, n_toggles, n_day_steps;

    function new();
      ticks = 0;
      polls = POLL_INTERVAL;
      led = 0;
      sec = 0; mins = 0; hr = 0;
      dy = 0; mon = 0; yr = 0; wd = 0;
      zone = 1'b0;
      cur_off = 2; first_off = 2; second_off = -4; ref_off = 2;
    endfunction

    function int signed5(logic [4:0] v);
      return v[4] ? int'(v) - 32 : int'(v);
    endfunction

    function bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Months outside 1..12 count as 31 days
    function int days_in(int m, int y);
      if (m < 1 || m > 12) return 31;
      if (m == int'(ccz_pkg::MONTH_FEB) && is_leap(y)) return 29;
      return month_len[m - 1];
    endfunction

    function void day_back();
      if (dy <= 1) begin
        if (mon <= 1) begin
          mon = int'(ccz_pkg::MONTH_DEC);
          yr = (yr == 0) ? int'(ccz_pkg::YEAR_MAX) : yr - 1;
        end else begin
          mon--;
        end
        dy = days_in(mon, yr);
      end else begin
        dy--;
      end
      wd = (wd <= 1) ? int'(ccz_pkg::WEEKDAY_SUN) : wd - 1;
      n_day_steps++;
    endfunction

    function void day_forward();
      dy++;
      if (dy > days_in(mon, yr)) begin
        dy = 1;
        mon++;
        if (mon > int'(ccz_pkg::MONTH_DEC)) begin
          mon = int'(ccz_pkg::MONTH_JAN);
          yr = (yr >= int'(ccz_pkg::YEAR_MAX)) ? 0 : yr + 1;
        end
      end
      wd = (wd == 0 || wd >= int'(ccz_pkg::WEEKDAY_SUN)) ? int'(ccz_pkg::WEEKDAY_MON)
                                                         : wd + 1;
      n_day_steps++;
    endfunction

    // Move the hours to a new offset, carrying one day per 24 hours
    function void move_to(int target);
      int h;
      h = hr + (target - cur_off);
      while (h < 0) begin
        h += 24;
        day_back();
      end
      while (h >= 24) begin
        h -= 24;
        day_forward();
      end
      hr = h;
      cur_off = target;
    endfunction

    // Note an accepted item and queue the reading it must produce
    function void take_item(ccz_pkg::item_t it);
      bit               evt;
      int               zref, d, target;
      ccz_pkg::result_t r;
      evt = 1'b0;
      if (it.mode == ccz_pkg::MODE_TICK) begin
        n_ticks++;
        // counter and LED first
        ticks++;
        if (ticks >= TICKS_PER_SECOND) begin
          ticks = 0;
          evt = 1'b1;
          led = 1;
        end else if (ticks == LED_ON_TICKS) begin
          led = 0;
        end
        // then the button poll
        if (polls != 0) begin
          polls--;
        end else begin
          polls = POLL_INTERVAL;
          if (it.button_pressed) begin
            zone ^= 1'b1;
            n_toggles++;
            move_to(zone ? second_off : first_off);
          end
        end
        // then the second advance; hours wrap with no date change
        if (evt) begin
          n_seconds++;
          sec++;
          if (sec >= 60) begin
            sec = 0;
            mins++;
            if (mins >= 60) begin
              mins = 0;
              hr++;
              if (hr >= 24) hr = 0;
            end
          end
        end
      end else begin
        n_sets++;
        zref = signed5(it.set_reference_zone);
        hr   = it.set_hours;
        mins = it.set_minutes;
        sec  = it.set_seconds;
        dy   = it.set_day;
        mon  = it.set_month;
        yr   = it.set_year;
        wd   = it.set_weekday;
        ticks = 0;
        // a new reference zone drags every offset along, wrapping in five bits
        if (zref != ref_off) begin
          d = zref - ref_off;
          first_off  = signed5(5'(first_off + d));
          second_off = signed5(5'(second_off + d));
          cur_off    = signed5(5'(cur_off + d));
          ref_off    = zref;
        end
        target  = cur_off;
        cur_off = zref;
        move_to(target);
      end
      r.hours          = 5'(hr);
      r.minutes        = 6'(mins);
      r.seconds        = 6'(sec);
      r.day            = 5'(dy);
      r.month          = 4'(mon);
      r.year           = 14'(yr);
      r.weekday        = 3'(wd);
      r.zone_is_second = zone;
      r.led_on         = led[0];
      r.second_event   = evt;
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Check one result transfer against the oldest expected reading
    function void check_reading(logic [47:0] word);
      ccz_pkg::result_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: result 0x%h with no expected reading waiting", $time, word);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      compare_field("hours", want.hours, word[4:0]);
      compare_field("minutes", want.minutes, word[10:5]);
      compare_field("seconds", want.seconds, word[16:11]);
      compare_field("day", want.day, word[21:17]);
      compare_field("month", want.month, word[25:22]);
      compare_field("year", want.year, word[39:26]);
      compare_field("weekday", want.weekday, word[42:40]);
      compare_field("zone_is_second", want.zone_is_second, word[43]);
      compare_field("led_on", want.led_on, word[44]);
      compare_field("second_event", want.second_event, word[45]);
    endfunction
  endclass

  calendar_tracker tracker = new();

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_off;
  int unsigned held;
  int unsigned sent;

  clock_calendar_with_zone_shift_unit #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .LED_ON_TICKS    (LED_ON_TICKS),
    .POLL_INTERVAL   (POLL_INTERVAL)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random stalls, or a long hold-off when asked
  initial begin
    out_tready = 1'b0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        held++;
        if (held >= HOLD_OFF_CYCLES) begin
          held = 0;
          hold_off = 1'b0;
        end
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_reading(out_tdata);
  end

  // Offer one item after a random idle stretch and hold it until the transfer
  task automatic send_item(input ccz_pkg::item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {7'b0, it.set_reference_zone, it.set_weekday, it.set_year, it.set_month,
                  it.set_day, it.set_seconds, it.set_minutes, it.set_hours,
                  it.button_pressed};
    do @(posedge clk); while (!in_tready);
    tracker.take_item(it);
    sent++;
  endtask

  // Raw random bits in every field; mode and button chosen by the caller
  function automatic ccz_pkg::item_t noise_item(logic mode, logic btn);
    logic [63:0]    r;
    ccz_pkg::item_t it;
    r = {$urandom, $urandom};
    it = r[$bits(ccz_pkg::item_t)-1:0];
    it.mode = mode;
    it.button_pressed = btn;
    return it;
  endfunction

  // A sensible set item, often just short of a rollover or at a month end
  function automatic ccz_pkg::item_t tidy_set_item();
    ccz_pkg::item_t it;
    bit             near_end;
    it = noise_item(ccz_pkg::MODE_SET, 1'($urandom));
    near_end = 1'($urandom);
    it.set_hours   = near_end ? ($urandom_range(1) ? ccz_pkg::LAST_HOUR : 5'd0)
                              : 5'($urandom_range(23));
    it.set_minutes = near_end ? ccz_pkg::LAST_MIN_SEC : 6'($urandom_range(59));
    it.set_seconds = near_end ? 6'($urandom_range(59, 57)) : 6'($urandom_range(59));
    it.set_day     = $urandom_range(1) ? 5'($urandom_range(31, 28))
                                       : ($urandom_range(1) ? 5'd1 : 5'($urandom_range(31, 1)));
    it.set_month   = 4'($urandom_range(12, 1));
    case ($urandom_range(7))
      0:       it.set_year = 14'd0;
      1:       it.set_year = ccz_pkg::YEAR_MAX;
      2:       it.set_year = 14'd2000;
      3:       it.set_year = 14'd1900;
      4:       it.set_year = 14'd2024;
      5:       it.set_year = 14'd2023;
      default: it.set_year = 14'($urandom_range(9999));
    endcase
    it.set_weekday = 3'($urandom_range(7, 1));
    it.set_reference_zone = 5'(int'($urandom_range(24)) - 12);
    return it;
  endfunction

  task automatic send_set(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s,
                          input logic [4:0] d, input logic [3:0] mo, input logic [13:0] y,
                          input logic [2:0] w, input int zone_ref);
    ccz_pkg::item_t it;
    it = noise_item(ccz_pkg::MODE_SET, 1'($urandom));
    it.set_hours = h;
    it.set_minutes = m;
    it.set_seconds = s;
    it.set_day = d;
    it.set_month = mo;
    it.set_year = y;
    it.set_weekday = w;
    it.set_reference_zone = 5'(zone_ref);
    send_item(it);
  endtask

  // Mostly a set followed by a run of ticks; the rest stray sets and short tick bursts
  task automatic run_sequences(input int unsigned count);
    int unsigned goal;
    int          len;
    int          style;
    goal = sent + count;
    while (sent < goal) begin
      if ($urandom_range(9) < 7) begin
        send_item(tidy_set_item());
        len = ($urandom_range(3) == 0) ? $urandom_range(220, 100) : $urandom_range(60, 1);
        style = $urandom_range(2);
        repeat (len) begin
          send_item(noise_item(ccz_pkg::MODE_TICK, (style == 0) ? 1'b1 :
                               (style == 1) ? 1'b0 : ($urandom_range(9) < 3)));
        end
      end else if ($urandom_range(1)) begin
        send_item(noise_item(ccz_pkg::MODE_SET, 1'($urandom)));
      end else begin
        repeat ($urandom_range(8, 1)) send_item(noise_item(ccz_pkg::MODE_TICK, 1'($urandom)));
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ccz_pkg::MODE_TICK;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b0;
    sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // press held from reset: zone toggles on the zero date before any set
    repeat (110) send_item(noise_item(ccz_pkg::MODE_TICK, 1'b1));

    // extremes, reference zone changes with offset wrap, leap rules, wild fields
    send_set(ccz_pkg::LAST_HOUR, ccz_pkg::LAST_MIN_SEC, ccz_pkg::LAST_MIN_SEC, 5'd31,
             ccz_pkg::MONTH_DEC, ccz_pkg::YEAR_MAX, ccz_pkg::WEEKDAY_SUN, 2);
    send_set(ccz_pkg::LAST_HOUR, ccz_pkg::LAST_MIN_SEC, ccz_pkg::LAST_MIN_SEC, 5'd31,
             ccz_pkg::MONTH_DEC, ccz_pkg::YEAR_MAX, ccz_pkg::WEEKDAY_SUN, -12);
    send_set(5'd0, 6'd0, 6'd0, 5'd1, ccz_pkg::MONTH_JAN, 14'd0, ccz_pkg::WEEKDAY_MON, 12);
    send_set(5'd31, 6'd63, 6'd63, 5'd31, 4'd15, 14'd16383, 3'd0, -16);
    send_set(5'd0, 6'd0, 6'd0, 5'd0, 4'd0, 14'd0, 3'd0, 0);
    send_set(ccz_pkg::LAST_HOUR, 6'd30, 6'd0, 5'd28, ccz_pkg::MONTH_FEB, 14'd2000, 3'd3, -12);
    send_set(5'd0, 6'd15, 6'd0, 5'd1, 4'd3, 14'd2024, 3'd5, 12);
    send_set(5'd1, 6'd0, 6'd0, 5'd28, ccz_pkg::MONTH_FEB, 14'd1900, ccz_pkg::WEEKDAY_SUN, -7);
    send_set(5'd22, ccz_pkg::LAST_MIN_SEC, ccz_pkg::LAST_MIN_SEC, 5'd30, 4'd4, 14'd2023,
             3'd6, 15);
    send_set(5'd0, 6'd0, 6'd0, 5'd29, ccz_pkg::MONTH_FEB, 14'd2400, 3'd2, -1);
    send_set(5'd12, 6'd34, 6'd56, 5'd15, 4'd13, 14'd1999, 3'd4, 3);
    repeat (12) send_item(noise_item(ccz_pkg::MODE_TICK, 1'($urandom)));

    // idling phases
    run_sequences(350);
    send_idle_pct = 52;
    run_sequences(350);
    send_idle_pct = 0;
    stall_pct = 52;
    run_sequences(350);
    send_idle_pct = 36;
    stall_pct = 36;
    run_sequences(350);

    // long result hold-off while ticks keep coming, so the input stalls
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b1;
    repeat (40) send_item(noise_item(ccz_pkg::MODE_TICK, 1'($urandom)));
    run_sequences(60);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.expected_readings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d ticks and %0d set items, %0d completed seconds, %0d results checked.",
             tracker.n_ticks, tracker.n_sets, tracker.n_seconds, tracker.checked);
    $display("Zone toggled %0d times and the date was carried %0d days.",
             tracker.n_toggles, tracker.n_day_steps);
    if (tracker.errors == 0 && tracker.expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", tracker.expected_readings.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
